// ===== rtl/core/fbgdr_pkg.sv =====
// Package with the word types, operation codes and font table of the glyph frame buffer.
package fbgdr_pkg;

  localparam logic [2:0] OP_WRITE = 3'd0;
  localparam logic [2:0] OP_READ  = 3'd1;
  localparam logic [2:0] OP_GLYPH = 3'd2;
  localparam logic [2:0] OP_CLEAR = 3'd3;
  localparam logic [2:0] OP_FLUSH = 3'd4;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  typedef struct packed {
    logic [2:0]        operation;
    logic signed [11:0] pixel_x;
    logic signed [11:0] pixel_y;
    logic [7:0]        color;
    logic [7:0]        background_color;
    logic [6:0]        char_code;
  } in_word_t;

  typedef struct packed {
    logic [7:0]        read_data;
    logic              dirty;
    logic signed [11:0] region_left;
    logic signed [11:0] region_top;
    logic signed [11:0] region_right;
    logic signed [11:0] region_bottom;
  } out_word_t;

  localparam logic [7:0] FONT [8][128] = '{
 '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
  8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
  8'h00,8'h08,8'h14,8'h14,8'h08,8'h00,8'h18,8'h08,8'h04,8'h10,8'h08,8'h08,8'h00,8'h00,8'h00,8'h01,
  8'h1C,8'h08,8'h1C,8'h1C,8'h0C,8'h3E,8'h1C,8'h3E,8'h1C,8'h1C,8'h00,8'h00,8'h04,8'h00,8'h20,8'h1C,
  8'h1C,8'h1C,8'h3C,8'h1C,8'h3C,8'h3E,8'h3E,8'h1C,8'h22,8'h1C,8'h0E,8'h22,8'h10,8'h41,8'h22,8'h1C,
  8'h1C,8'h1C,8'h3C,8'h1C,8'h3E,8'h22,8'h22,8'h41,8'h22,8'h22,8'h3E,8'h1C,8'h40,8'h1C,8'h08,8'h00,
  8'h10,8'h00,8'h10,8'h00,8'h02,8'h00,8'h0C,8'h00,8'h20,8'h00,8'h00,8'h20,8'h18,8'h00,8'h00,8'h00,
  8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h0C,8'h08,8'h30,8'h00,8'h00},
 '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
  8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
  8'h00,8'h08,8'h14,8'h14,8'h1E,8'h32,8'h28,8'h08,8'h08,8'h08,8'h49,8'h08,8'h00,8'h00,8'h00,8'h02,
  8'h22,8'h18,8'h22,8'h22,8'h14,8'h20,8'h22,8'h02,8'h22,8'h22,8'h0C,8'h0C,8'h08,8'h00,8'h10,8'h22,
  8'h22,8'h22,8'h22,8'h22,8'h22,8'h20,8'h20,8'h22,8'h22,8'h08,8'h04,8'h22,8'h10,8'h63,8'h32,8'h22,
  8'h12,8'h22,8'h22,8'h22,8'h08,8'h22,8'h22,8'h41,8'h22,8'h22,8'h02,8'h10,8'h20,8'h04,8'h14,8'h00,
  8'h08,8'h1C,8'h10,8'h00,8'h02,8'h00,8'h12,8'h00,8'h20,8'h08,8'h08,8'h20,8'h08,8'h00,8'h00,8'h00,
  8'h00,8'h00,8'h00,8'h00,8'h08,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h10,8'h08,8'h08,8'h00,8'h00},
 '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
  8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
  8'h00,8'h08,8'h00,8'h7F,8'h28,8'h34,8'h10,8'h00,8'h10,8'h04,8'h2A,8'h08,8'h00,8'h00,8'h00,8'h04,
  8'h22,8'h08,8'h02,8'h02,8'h24,8'h20,8'h20,8'h04,8'h22,8'h22,8'h0C,8'h0C,8'h10,8'h7F,8'h08,8'h02,
  8'h2E,8'h22,8'h22,8'h20,8'h22,8'h20,8'h20,8'h20,8'h22,8'h08,8'h04,8'h24,8'h10,8'h55,8'h2A,8'h22,
  8'h12,8'h22,8'h22,8'h20,8'h08,8'h22,8'h22,8'h41,8'h14,8'h14,8'h04,8'h10,8'h10,8'h04,8'h22,8'h00,
  8'h00,8'h02,8'h1C,8'h1C,8'h0E,8'h1C,8'h10,8'h1D,8'h2C,8'h00,8'h00,8'h24,8'h08,8'hB6,8'h2C,8'h1C,
  8'h2C,8'h1A,8'h2C,8'h1C,8'h1C,8'h24,8'h22,8'h41,8'h22,8'h12,8'h3C,8'h10,8'h08,8'h08,8'h30,8'h00},
 '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
  8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
  8'h00,8'h08,8'h00,8'h14,8'h1C,8'h08,8'h28,8'h00,8'h10,8'h04,8'h1C,8'h7F,8'h00,8'h7F,8'h00,8'h08,
  8'h2A,8'h08,8'h04,8'h0C,8'h3E,8'h3C,8'h3C,8'h08,8'h1C,8'h1E,8'h00,8'h00,8'h20,8'h00,8'h04,8'h04,
  8'h2A,8'h3E,8'h3C,8'h20,8'h22,8'h3C,8'h3E,8'h2E,8'h3E,8'h08,8'h04,8'h38,8'h10,8'h49,8'h2A,8'h22,
  8'h1C,8'h22,8'h3C,8'h1C,8'h08,8'h22,8'h14,8'h2A,8'h08,8'h08,8'h08,8'h10,8'h08,8'h04,8'h00,8'h00,
  8'h00,8'h1E,8'h12,8'h20,8'h12,8'h22,8'h38,8'h22,8'h32,8'h08,8'h08,8'h28,8'h08,8'h49,8'h12,8'h22,
  8'h12,8'h24,8'h30,8'h20,8'h08,8'h24,8'h22,8'h41,8'h14,8'h12,8'h04,8'h20,8'h08,8'h04,8'h49,8'h00},
 '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
  8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
  8'h00,8'h08,8'h00,8'h7F,8'h0A,8'h16,8'h46,8'h00,8'h10,8'h04,8'h2A,8'h08,8'h0C,8'h00,8'h00,8'h10,
  8'h22,8'h08,8'h08,8'h02,8'h04,8'h02,8'h22,8'h10,8'h22,8'h02,8'h0C,8'h0C,8'h10,8'h7F,8'h08,8'h08,
  8'h2E,8'h22,8'h22,8'h20,8'h22,8'h20,8'h20,8'h22,8'h22,8'h08,8'h24,8'h24,8'h10,8'h41,8'h26,8'h22,
  8'h10,8'h22,8'h28,8'h02,8'h08,8'h22,8'h14,8'h2A,8'h14,8'h08,8'h10,8'h10,8'h04,8'h04,8'h00,8'h00,
  8'h00,8'h22,8'h12,8'h20,8'h12,8'h3E,8'h10,8'h22,8'h22,8'h08,8'h08,8'h30,8'h08,8'h49,8'h12,8'h22,
  8'h12,8'h24,8'h20,8'h18,8'h08,8'h24,8'h22,8'h49,8'h08,8'h12,8'h08,8'h10,8'h08,8'h08,8'h06,8'h00},
 '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
  8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
  8'h00,8'h00,8'h00,8'h14,8'h3C,8'h26,8'h44,8'h00,8'h08,8'h08,8'h49,8'h08,8'h0C,8'h00,8'h0C,8'h20,
  8'h22,8'h08,8'h10,8'h22,8'h04,8'h22,8'h22,8'h10,8'h22,8'h22,8'h0C,8'h0C,8'h08,8'h00,8'h10,8'h00,
  8'h20,8'h22,8'h22,8'h22,8'h22,8'h20,8'h20,8'h22,8'h22,8'h08,8'h24,8'h22,8'h10,8'h41,8'h22,8'h22,
  8'h10,8'h22,8'h24,8'h22,8'h08,8'h22,8'h08,8'h14,8'h22,8'h08,8'h20,8'h10,8'h02,8'h04,8'h00,8'h00,
  8'h00,8'h22,8'h12,8'h20,8'h12,8'h20,8'h10,8'h1E,8'h22,8'h08,8'h08,8'h28,8'h08,8'h41,8'h12,8'h22,
  8'h1C,8'h1C,8'h20,8'h04,8'h08,8'h24,8'h14,8'h55,8'h14,8'h0E,8'h10,8'h10,8'h08,8'h08,8'h00,8'h00},
 '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
  8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
  8'h00,8'h08,8'h00,8'h14,8'h08,8'h00,8'h3A,8'h00,8'h04,8'h10,8'h08,8'h08,8'h04,8'h00,8'h0C,8'h40,
  8'h1C,8'h1C,8'h3E,8'h1C,8'h0E,8'h1C,8'h1C,8'h10,8'h1C,8'h1C,8'h00,8'h04,8'h04,8'h00,8'h20,8'h08,
  8'h1C,8'h22,8'h3C,8'h1C,8'h3C,8'h3E,8'h20,8'h1C,8'h22,8'h1C,8'h18,8'h22,8'h1E,8'h41,8'h22,8'h1C,
  8'h10,8'h1C,8'h22,8'h1C,8'h08,8'h1C,8'h08,8'h14,8'h22,8'h08,8'h3E,8'h1C,8'h01,8'h1C,8'h00,8'h00,
  8'h00,8'h1D,8'h2C,8'h1C,8'h0D,8'h1C,8'h10,8'h02,8'h22,8'h08,8'h08,8'h24,8'h08,8'h41,8'h12,8'h1C,
  8'h10,8'h04,8'h20,8'h38,8'h08,8'h1A,8'h08,8'h22,8'h22,8'h02,8'h3C,8'h0C,8'h08,8'h30,8'h00,8'h00},
 '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
  8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
  8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h08,8'h00,8'h00,8'h00,
  8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h08,8'h00,8'h00,8'h00,8'h00,
  8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
  8'h00,8'h06,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h7F,
  8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h1C,8'h00,8'h00,8'h30,8'h00,8'h00,8'h00,8'h00,8'h00,
  8'h10,8'h04,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h1C,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}
  };

endpackage

// ===== rtl/core/framebuffer_glyph_dirty_rect.sv =====
// Top level of the indexed frame buffer with dirty rectangle and glyph drawing.
// One word is taken while busy is low. A pixel write or an unused code goes to the done
// state, which registers its result word; a pixel read or a flush first passes the read
// state for the registered memory read; a glyph draw walks its 64 pixels through the
// single memory write port, one per cycle, and then reports; a clear writes zero to
// every one of the MAX_PITCH*MAX_HEIGHT entries, one per cycle, and reports when done.
// After reset the same clearing pass runs with busy high. Results appear on out_word for
// one cycle with out_valid and cannot be held off.
module framebuffer_glyph_dirty_rect
  import fbgdr_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word,
  input  logic      psel,
  input  logic      penable,
  input  logic      pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic      pready
);

  localparam int MAX_PITCH = (MAX_WIDTH + 3) / 4 * 4;
  localparam int DEPTH     = MAX_PITCH * MAX_HEIGHT;
  localparam int AW        = $clog2(DEPTH);
  localparam int WW        = $clog2(MAX_WIDTH + 1);
  localparam int HW        = $clog2(MAX_HEIGHT + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_GLYPH = 3'd2;
  localparam logic [2:0] ST_CLEAR = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [10:0] width_r, height_r;
  in_word_t    cmd_r;
  logic [5:0]  step_r;
  logic [AW-1:0] clr_r;
  logic        init_r;
  logic        dirty_r;
  logic signed [11:0] bl_r, bt_r, br_r, bb_r;
  logic        rd_ok_r;
  logic        pending_flush_r;

  // Register writes and reads.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd640;
      height_r <= 11'd480;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      if (paddr[2] == REG_WIDTH[0]) width_r <= pwdata[10:0];
      else if (paddr[2] == REG_HEIGHT[0]) height_r <= pwdata[10:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr == {REG_WIDTH[0], 2'b00}) prdata = {21'd0, width_r};
    else if (paddr == {REG_HEIGHT[0], 2'b00}) prdata = {21'd0, height_r};
  end

  // Saturated frame size and row pitch.
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [WW-1:0] pitch;
  always_comb begin
    if (width_r == 11'd0) eff_w = WW'(1);
    else if (32'(width_r) > MAX_WIDTH) eff_w = WW'(MAX_WIDTH);
    else eff_w = WW'(width_r);
    if (height_r == 11'd0) eff_h = HW'(1);
    else if (32'(height_r) > MAX_HEIGHT) eff_h = HW'(MAX_HEIGHT);
    else eff_h = HW'(height_r);
  end
  assign pitch = WW'((32'(eff_w) + 3) & ~32'd3);

  // The pixel under work: the command itself, or one cell of the glyph.
  logic signed [12:0] px, py;
  logic [7:0] pcolor;
  logic [7:0] font_bits;
  assign font_bits = FONT[step_r[5:3]][cmd_r.char_code];
  always_comb begin
    if (state_r == ST_GLYPH) begin
      px = 13'(cmd_r.pixel_x) + 13'(step_r[2:0]);
      py = 13'(cmd_r.pixel_y) + 13'(step_r[5:3]);
      pcolor = font_bits[3'd7 - step_r[2:0]] ? cmd_r.color : cmd_r.background_color;
    end else begin
      px = 13'(cmd_r.pixel_x);
      py = 13'(cmd_r.pixel_y);
      pcolor = cmd_r.color;
    end
  end

  // Bounds check and store address of that pixel.
  logic in_range;
  logic [HW-1:0] srow;
  logic [AW-1:0] paddr_px;
  assign in_range = !px[12] && !py[12] && (px < $signed({1'b0, 12'(eff_w)}))
                    && (py < $signed({1'b0, 12'(eff_h)}));
  assign srow = eff_h - HW'(1) - HW'(py[11:0]);
  assign paddr_px = AW'(srow) * AW'(pitch) + AW'(px[11:0]);

  // Memory port control.
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata, rdata;
  logic          plot;
  assign plot = in_range && ((state_r == ST_GLYPH) ||
                (state_r == ST_DONE && cmd_r.operation == OP_WRITE && !pending_flush_r));
  always_comb begin
    we = plot;
    waddr = paddr_px;
    wdata = pcolor;
    if (state_r == ST_CLEAR) begin
      we = 1'b1;
      waddr = clr_r;
      wdata = 8'd0;
    end
  end

  fbgdr_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(paddr_px), .rdata(rdata)
  );

  // Sequencer.
  logic accept;
  assign busy = (state_r != ST_IDLE);
  assign accept = start && !busy;
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_word.operation)
            OP_READ, OP_FLUSH: state_nxt = ST_READ;
            OP_GLYPH: state_nxt = ST_GLYPH;
            OP_CLEAR: state_nxt = ST_CLEAR;
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_READ: state_nxt = ST_DONE;
      ST_GLYPH: if (step_r == 6'd63) state_nxt = ST_DONE;
      ST_CLEAR: if (32'(clr_r) == DEPTH - 1) state_nxt = init_r ? ST_IDLE : ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Box growth for a plotted pixel.
  logic signed [11:0] x1, y1, xp1, yp1;
  assign x1  = px[11:0];
  assign y1  = py[11:0];
  assign xp1 = px[11:0] + 12'sd1;
  assign yp1 = py[11:0] + 12'sd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      init_r  <= 1'b1;
      clr_r   <= '0;
      step_r  <= '0;
      dirty_r <= 1'b0;
      bl_r <= -12'sd1; bt_r <= -12'sd1; br_r <= -12'sd1; bb_r <= -12'sd1;
      out_valid <= 1'b0;
      pending_flush_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= 1'b0;
      if (accept) begin
        cmd_r  <= in_word;
        step_r <= '0;
        clr_r  <= '0;
        pending_flush_r <= 1'b0;
      end
      if (state_r == ST_READ) begin
        rd_ok_r <= in_range;
        pending_flush_r <= (cmd_r.operation == OP_FLUSH);
      end
      if (state_r == ST_GLYPH) step_r <= step_r + 6'd1;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + AW'(1);
        if (32'(clr_r) == DEPTH - 1) begin
          if (init_r) init_r <= 1'b0;
          else begin
            dirty_r <= 1'b1;
            bl_r <= 12'sd0; bt_r <= 12'sd0;
            br_r <= 12'(eff_w); bb_r <= 12'(eff_h);
          end
        end
      end
      if (plot) begin
        dirty_r <= 1'b1;
        if (bl_r < 0) begin
          bl_r <= x1; br_r <= xp1; bt_r <= y1; bb_r <= yp1;
        end else begin
          if (x1 < bl_r) bl_r <= x1;
          if (xp1 > br_r) br_r <= xp1;
          if (y1 < bt_r) bt_r <= y1;
          if (yp1 > bb_r) bb_r <= yp1;
        end
      end
      // Result word; a flush empties the box after reporting it.
      if (state_r == ST_DONE) begin
        out_valid <= 1'b1;
        out_word.read_data <= (cmd_r.operation == OP_READ && rd_ok_r) ? rdata : 8'd0;
        out_word.dirty        <= dirty_r || plot;
        if (plot && bl_r < 0) begin
          out_word.region_left <= x1; out_word.region_right <= xp1;
          out_word.region_top  <= y1; out_word.region_bottom <= yp1;
        end else if (plot) begin
          out_word.region_left   <= (x1 < bl_r) ? x1 : bl_r;
          out_word.region_right  <= (xp1 > br_r) ? xp1 : br_r;
          out_word.region_top    <= (y1 < bt_r) ? y1 : bt_r;
          out_word.region_bottom <= (yp1 > bb_r) ? yp1 : bb_r;
        end else begin
          out_word.region_left <= bl_r; out_word.region_top <= bt_r;
          out_word.region_right <= br_r; out_word.region_bottom <= bb_r;
        end
        if (cmd_r.operation == OP_FLUSH && dirty_r) begin
          dirty_r <= 1'b0;
          bl_r <= -12'sd1; bt_r <= -12'sd1; br_r <= -12'sd1; bb_r <= -12'sd1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  // A result word only leaves from the final state.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == ST_DONE) else $error("result outside done state");
  // A dirty box always has a valid left edge.
  assert property (@(posedge clk) disable iff (!rst_n)
    dirty_r |-> bl_r >= 0) else $error("dirty flag without box");
  // No word is accepted while the clear pass runs.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> busy) else $error("clear pass not busy");
`endif

endmodule

// ===== rtl/core/fbgdr_ram.sv =====
// Generic simple dual-port RAM with one write and one registered read per cycle.
module fbgdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
